@@ hw/rtl/ntfp_pkg.sv @@
// Shared types, constants and helper functions for the numeric text parser.
package ntfp_pkg;

    // Fixed-point format of the result
    localparam int FRAC_BITS = 16;
    localparam int INT_BITS  = 31;
    localparam int MAG_BITS  = INT_BITS + FRAC_BITS;
    localparam int OUT_BITS  = MAG_BITS + 1;
    // Magnitudes hold up to and including the cap
    localparam int MAGW      = MAG_BITS + 1;
    // Room for a magnitude times 3600 plus another magnitude
    localparam int SUMW      = MAGW + 14;

    typedef logic [MAGW-1:0] mag_t;
    typedef logic [SUMW-1:0] sum_t;

    localparam mag_t CAP = {1'b1, {MAG_BITS{1'b0}}};
    localparam logic [OUT_BITS-1:0] POS_LIMIT = {1'b0, {MAG_BITS{1'b1}}};
    localparam logic [OUT_BITS-1:0] NEG_LIMIT = {1'b1, {MAG_BITS{1'b0}}};

    localparam int HOUR_SCALE   = 3600;
    localparam int MINUTE_SCALE = 60;

    // Character codes
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_F   = 8'h46;
    localparam logic [7:0] CH_LC_X   = 8'h78;
    localparam logic [7:0] CH_UC_X   = 8'h58;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_COLON  = 8'h3A;

    // Digit decode result for a byte that is no digit
    localparam logic [4:0] NO_DIGIT = 5'd16;

    // Fraction weight index saturates here; its weight is zero
    localparam logic [3:0] FRAC_IDX_LAST = 4'd9;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_SEG   = 3'd1,
        PH_ZERO  = 3'd2,
        PH_INT   = 3'd3,
        PH_FRAC  = 3'd4,
        PH_DONE  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        BASE_DEC = 2'd0,
        BASE_OCT = 2'd1,
        BASE_HEX = 2'd2
    } base_t;

    // Parser state carried from one character to the next
    typedef struct packed {
        phase_t     phase;
        logic       negative;
        base_t      base;
        mag_t       segment_value;
        mag_t       time_total;
        logic [3:0] frac_idx;
        logic       clamp;
    } parse_state_t;

    localparam parse_state_t STATE_INIT = '{
        phase:         PH_START,
        negative:      1'b0,
        base:          BASE_DEC,
        segment_value: '0,
        time_total:    '0,
        frac_idx:      '0,
        clamp:         1'b0
    };

    // Input and output words
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } in_word_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] parsed_value;
        logic                       saturated;
    } out_word_t;

    // Q0.32 weight of the n-th fraction digit: 0.1 rounded, then (w+5)/10 each step
    function automatic logic [31:0] frac_weight(input logic [3:0] idx);
        logic [31:0] w;
        begin
            unique case (idx)
                4'd0:    w = 32'd429496730;
                4'd1:    w = 32'd42949673;
                4'd2:    w = 32'd4294967;
                4'd3:    w = 32'd429497;
                4'd4:    w = 32'd42950;
                4'd5:    w = 32'd4295;
                4'd6:    w = 32'd430;
                4'd7:    w = 32'd43;
                4'd8:    w = 32'd4;
                default: w = 32'd0;
            endcase
            return w;
        end
    endfunction

    // Value of a hex digit in any case, NO_DIGIT otherwise
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [4:0] d;
        begin
            if (c >= CH_ZERO && c <= CH_NINE)
                d = 5'(c - CH_ZERO);
            else if (c >= CH_LC_A && c <= CH_LC_F)
                d = 5'(c - CH_LC_A) + 5'd10;
            else if (c >= CH_UC_A && c <= CH_UC_F)
                d = 5'(c - CH_UC_A) + 5'd10;
            else
                d = NO_DIGIT;
            return d;
        end
    endfunction

    // Clip a wide sum to the cap
    function automatic mag_t clip_mag(input sum_t v);
        begin
            return (v > sum_t'(CAP)) ? CAP : mag_t'(v);
        end
    endfunction

endpackage

@@ hw/rtl/ntfp_step.sv @@
// Next-state and result logic for one character or end word of the parser.
module ntfp_step
(
    input  ntfp_pkg::parse_state_t state,
    input  logic [7:0]             char_code,
    input  logic                   end_of_text,
    output ntfp_pkg::parse_state_t state_next,
    output ntfp_pkg::out_word_t    result
);

    ntfp_pkg::phase_t ph;
    ntfp_pkg::base_t  base;
    logic             consumed;
    logic             do_end;
    logic [4:0]       dig;
    logic [4:0]       radix;
    logic [3:0]       dec_dig;
    logic             is_dec;

    ntfp_pkg::sum_t   mul8;
    ntfp_pkg::sum_t   mul10;
    ntfp_pkg::sum_t   mul16;
    ntfp_pkg::sum_t   digit_add;
    ntfp_pkg::sum_t   int_sum;
    logic [35:0]      frac_prod;
    logic [35:0]      frac_term;
    ntfp_pkg::sum_t   frac_sum;
    ntfp_pkg::sum_t   seg_wide;
    ntfp_pkg::sum_t   hour_sum;
    ntfp_pkg::sum_t   min_sum;
    ntfp_pkg::sum_t   end_sum;
    ntfp_pkg::mag_t   end_mag;
    logic             end_clip;

    // Character decode
    assign dig     = ntfp_pkg::digit_of(char_code);
    assign is_dec  = (char_code >= ntfp_pkg::CH_ZERO) && (char_code <= ntfp_pkg::CH_NINE);
    assign dec_dig = 4'(char_code - ntfp_pkg::CH_ZERO);

    // Integer digit: value * radix + digit, radix products as shift-adds
    assign mul8      = ntfp_pkg::sum_t'(state.segment_value) << 3;
    assign mul16     = ntfp_pkg::sum_t'(state.segment_value) << 4;
    assign mul10     = (ntfp_pkg::sum_t'(state.segment_value) << 3)
                     + (ntfp_pkg::sum_t'(state.segment_value) << 1);
    assign digit_add = ntfp_pkg::sum_t'(dig[3:0]) << ntfp_pkg::FRAC_BITS;

    // Fraction digit: digit * weight, rounded to FRAC_BITS
    assign frac_prod = 36'(dec_dig) * 36'(ntfp_pkg::frac_weight(state.frac_idx));
    assign frac_term = (frac_prod + (36'd1 << (31 - ntfp_pkg::FRAC_BITS)))
                       >> (32 - ntfp_pkg::FRAC_BITS);
    assign frac_sum  = ntfp_pkg::sum_t'(state.segment_value) + ntfp_pkg::sum_t'(frac_term);

    // Hour and minute accumulation: 3600 = 4096 - 512 + 16, 60 = 64 - 4
    assign seg_wide = ntfp_pkg::sum_t'(state.segment_value);
    assign hour_sum = (seg_wide << 12) - (seg_wide << 9) + (seg_wide << 4)
                    + ntfp_pkg::sum_t'(state.time_total);
    assign min_sum  = (seg_wide << 6) - (seg_wide << 2)
                    + ntfp_pkg::sum_t'(state.time_total);

    // Final magnitude on the end word
    assign end_sum  = ntfp_pkg::sum_t'(state.segment_value)
                    + ntfp_pkg::sum_t'(state.time_total);
    assign end_clip = end_sum > ntfp_pkg::sum_t'(ntfp_pkg::CAP);
    assign end_mag  = ntfp_pkg::clip_mag(end_sum);

    // Result word, only meaningful on the end word
    always_comb
    begin
        result.saturated = state.clamp | end_clip;
        if (state.negative)
        begin
            result.parsed_value = $signed(ntfp_pkg::OUT_BITS'(0) - end_mag);
        end
        else if (end_mag == ntfp_pkg::CAP)
        begin
            result.parsed_value = $signed(ntfp_pkg::POS_LIMIT);
            result.saturated    = 1'b1;
        end
        else
        begin
            result.parsed_value = $signed(end_mag);
        end
    end

    // Parse step: phases fall through within one character
    always_comb
    begin
        state_next = state;
        ph         = state.phase;
        base       = state.base;
        consumed   = 1'b0;
        do_end     = 1'b0;
        radix      = 5'd10;
        int_sum    = mul10 + digit_add;

        // optional sign, first byte only
        if (ph == ntfp_pkg::PH_START)
        begin
            ph = ntfp_pkg::PH_SEG;
            if (char_code == ntfp_pkg::CH_MINUS)
            begin
                state_next.negative = 1'b1;
                consumed = 1'b1;
            end
            else if (char_code == ntfp_pkg::CH_PLUS)
            begin
                consumed = 1'b1;
            end
        end

        // leading zero selects octal or hex
        if (!consumed && ph == ntfp_pkg::PH_SEG)
        begin
            if (char_code == ntfp_pkg::CH_ZERO)
            begin
                ph = ntfp_pkg::PH_ZERO;
                consumed = 1'b1;
            end
            else
            begin
                ph = ntfp_pkg::PH_INT;
            end
        end

        if (!consumed && ph == ntfp_pkg::PH_ZERO)
        begin
            ph = ntfp_pkg::PH_INT;
            if (char_code == ntfp_pkg::CH_LC_X || char_code == ntfp_pkg::CH_UC_X)
            begin
                base = ntfp_pkg::BASE_HEX;
                consumed = 1'b1;
            end
            else
            begin
                base = ntfp_pkg::BASE_OCT;
            end
        end

        unique case (base)
            ntfp_pkg::BASE_OCT:
            begin
                radix   = 5'd8;
                int_sum = mul8 + digit_add;
            end
            ntfp_pkg::BASE_HEX:
            begin
                radix   = 5'd16;
                int_sum = mul16 + digit_add;
            end
            default:
            begin
                radix   = 5'd10;
                int_sum = mul10 + digit_add;
            end
        endcase

        // integer digits
        if (!consumed && ph == ntfp_pkg::PH_INT)
        begin
            if (dig < radix)
            begin
                state_next.segment_value = ntfp_pkg::clip_mag(int_sum);
                if (int_sum > ntfp_pkg::sum_t'(ntfp_pkg::CAP))
                    state_next.clamp = 1'b1;
            end
            else if (char_code == ntfp_pkg::CH_POINT || char_code == ntfp_pkg::CH_COMMA)
            begin
                state_next.frac_idx = '0;
                ph = ntfp_pkg::PH_FRAC;
            end
            else
            begin
                do_end = 1'b1;
            end
        end
        // fraction digits, always decimal
        else if (!consumed && ph == ntfp_pkg::PH_FRAC)
        begin
            if (is_dec)
            begin
                state_next.segment_value = ntfp_pkg::clip_mag(frac_sum);
                if (frac_sum > ntfp_pkg::sum_t'(ntfp_pkg::CAP))
                    state_next.clamp = 1'b1;
                if (state.frac_idx != ntfp_pkg::FRAC_IDX_LAST)
                    state_next.frac_idx = state.frac_idx + 4'd1;
            end
            else
            begin
                do_end = 1'b1;
            end
        end

        // segment terminator: hours, minutes, or end of parse
        if (do_end)
        begin
            if (char_code == ntfp_pkg::CH_QUOTE)
            begin
                state_next.time_total = ntfp_pkg::clip_mag(hour_sum);
                if (hour_sum > ntfp_pkg::sum_t'(ntfp_pkg::CAP))
                    state_next.clamp = 1'b1;
                state_next.segment_value = '0;
                state_next.frac_idx      = '0;
                base = ntfp_pkg::BASE_DEC;
                ph   = ntfp_pkg::PH_SEG;
            end
            else if (char_code == ntfp_pkg::CH_COLON || char_code == ntfp_pkg::CH_DQUOTE)
            begin
                state_next.time_total = ntfp_pkg::clip_mag(min_sum);
                if (min_sum > ntfp_pkg::sum_t'(ntfp_pkg::CAP))
                    state_next.clamp = 1'b1;
                state_next.segment_value = '0;
                state_next.frac_idx      = '0;
                base = ntfp_pkg::BASE_DEC;
                ph   = ntfp_pkg::PH_SEG;
            end
            else
            begin
                ph = ntfp_pkg::PH_DONE;
            end
        end

        state_next.phase = ph;
        state_next.base  = base;

        // end word: emit and start over
        if (end_of_text)
            state_next = ntfp_pkg::STATE_INIT;
    end

endmodule

@@ hw/rtl/numeric_text_to_fixed_parser_unit.sv @@
// Top level of the numeric text parser: input register, parse state, result register.
//
//  channel | direction | word                   | handshake
//  --------+-----------+------------------------+---------------------
//  in      | input     | char_code, end_of_text | in_valid / in_ready
//  out     | output    | parsed_value, saturated| out_valid / out_ready
//
// One word per cycle while no end word is stalled: a word waits in the input
// register, then the parse step updates the state register in a single pass.
// An end word shows its result on out the cycle after it leaves
// the input register, through the result register.
// Character words never wait on the output; only an end word stalls while a
// previous result is still held in the result register.
// Reset (rst_n low) returns the parser to the start of a text and empties
// both registers.
module numeric_text_to_fixed_parser_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ntfp_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output ntfp_pkg::out_word_t out_data
);

    logic                   in_vld_reg;
    ntfp_pkg::in_word_t     in_word_reg;
    ntfp_pkg::parse_state_t state_reg;
    ntfp_pkg::parse_state_t state_next;
    ntfp_pkg::out_word_t    result;
    logic                   out_vld_reg;
    logic                   out_vld_next;
    ntfp_pkg::out_word_t    out_word_reg;
    logic                   step_go;
    logic                   emit;

    // Input stage advances unless an end word meets a full, stalled output
    assign step_go  = in_vld_reg &&
                      (!in_word_reg.end_of_text || !out_vld_reg || out_ready);
    assign emit     = step_go && in_word_reg.end_of_text;
    assign in_ready = !in_vld_reg || step_go;

    assign out_vld_next = emit ? 1'b1 : (out_ready ? 1'b0 : out_vld_reg);

    ntfp_step u_step
    (
        .state       (state_reg),
        .char_code   (in_word_reg.char_code),
        .end_of_text (in_word_reg.end_of_text),
        .state_next  (state_next),
        .result      (result)
    );

    // Control and parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= ntfp_pkg::STATE_INIT;
        end
        else
        begin
            if (in_ready)
                in_vld_reg <= in_valid;
            if (step_go)
                state_reg <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_word_reg <= in_data;
        if (emit)
            out_word_reg <= result;
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_word_reg;

endmodule

@@ hw/rtl/ntfp_checker.sv @@
// Port-level checker for the numeric text parser, bound to the top level.
module ntfp_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input ntfp_pkg::in_word_t  in_data,
    input logic                out_valid,
    input logic                out_ready,
    input ntfp_pkg::out_word_t out_data
);

    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic       end_in;
    logic       word_out;

    assign end_in   = in_valid && in_ready && in_data.end_of_text;
    assign word_out = out_valid && out_ready;

    // End words taken but not yet delivered
    always_comb
    begin
        pending_next = pending_reg;
        if (end_in && !word_out)
            pending_next = pending_reg + 2'd1;
        else if (!end_in && word_out)
            pending_next = pending_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // Input only backs up behind a stalled output
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    // Every result belongs to an end word, and at most two are in flight
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || pending_reg != 2'd0) && pending_reg != 2'd3)
        else $error("result without a matching end word");

    // A saturated result sits at one of the range limits
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.saturated |->
            $unsigned(out_data.parsed_value) == ntfp_pkg::POS_LIMIT ||
            $unsigned(out_data.parsed_value) == ntfp_pkg::NEG_LIMIT)
        else $error("saturated result off the range limits");

endmodule

bind numeric_text_to_fixed_parser_unit ntfp_checker u_ntfp_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
